[hdl/ldbp_pkg.sv]
package ldbp_pkg;

    localparam int unsigned MAX_BLOCKS        = 12;
    localparam int unsigned RECORDS_PER_BLOCK = 32;

    localparam logic [10:0] MODE_OFFSET_RESET = 11'd1204;

    localparam logic [7:0] FLAG_BYTE_HI = 8'hFF;
    localparam logic [7:0] FLAG_BYTE_LO = 8'hEE;

    localparam logic [7:0] MODE_BYTE_STRONGEST = 8'h37;
    localparam logic [7:0] MODE_BYTE_LAST      = 8'h38;
    localparam logic [7:0] MODE_BYTE_DUAL      = 8'h39;

    localparam logic [1:0] MODE_STRONGEST = 2'd0;
    localparam logic [1:0] MODE_LAST      = 2'd1;
    localparam logic [1:0] MODE_DUAL      = 2'd2;
    localparam logic [1:0] MODE_UNKNOWN   = 2'd3;

    localparam logic KIND_POINT = 1'b0;
    localparam logic KIND_MODE  = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_start;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [3:0]  block_index;
        logic [4:0]  channel_index;
        logic [15:0] azimuth_centideg;
        logic [15:0] distance_units;
        logic [7:0]  reflectivity;
        logic [1:0]  return_mode;
        logic        last_of_block;
    } out_item_t;

    function automatic logic [1:0] decode_mode(input logic [7:0] b);
        logic [1:0] m;
        case (b)
            MODE_BYTE_STRONGEST: m = MODE_STRONGEST;
            MODE_BYTE_LAST:      m = MODE_LAST;
            MODE_BYTE_DUAL:      m = MODE_DUAL;
            default:             m = MODE_UNKNOWN;
        endcase
        return m;
    endfunction

endpackage

[hdl/ldbp_parser.sv]
module ldbp_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  ldbp_pkg::in_item_t in_item,
    input  logic [10:0]        mode_offset,
    output ldbp_pkg::out_item_t result,
    output logic               result_valid
);
    import ldbp_pkg::*;

    localparam logic [1:0] PH_SEARCH = 2'd0;
    localparam logic [1:0] PH_AZIM   = 2'd1;
    localparam logic [1:0] PH_REC    = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic        ff_reg, ff_next;
    logic [10:0] pos_reg, pos_next;
    logic [3:0]  blk_reg, blk_next;
    logic [4:0]  rec_reg, rec_next;
    logic [1:0]  bif_reg, bif_next;
    logic [15:0] az_reg, az_next;
    logic [15:0] dist_reg, dist_next;

    logic [1:0]  phase_cur;
    logic        ff_cur;
    logic [10:0] pos_cur;
    logic [3:0]  blk_cur;
    logic [4:0]  rec_cur;
    logic [1:0]  bif_cur;
    logic        point;
    logic        last;
    logic        is_mode;
    logic [7:0]  b;

    always_comb
    begin
        b = in_item.data_byte;

        // A start mark abandons whatever the previous packet left behind.
        if (in_item.packet_start)
        begin
            phase_cur = PH_SEARCH;
            ff_cur    = 1'b0;
            pos_cur   = '0;
            blk_cur   = '0;
            rec_cur   = '0;
            bif_cur   = '0;
        end
        else
        begin
            phase_cur = phase_reg;
            ff_cur    = ff_reg;
            pos_cur   = pos_reg;
            blk_cur   = blk_reg;
            rec_cur   = rec_reg;
            bif_cur   = bif_reg;
        end

        is_mode    = (pos_cur == mode_offset);
        point      = 1'b0;
        last       = ({1'b0, rec_cur} + 6'd1) >= 6'(RECORDS_PER_BLOCK);
        phase_next = phase_cur;
        ff_next    = ff_cur;
        blk_next   = blk_cur;
        rec_next   = rec_cur;
        bif_next   = bif_cur;
        az_next    = az_reg;
        dist_next  = dist_reg;
        pos_next   = pos_cur + 11'd1;

        case (phase_cur)
            PH_AZIM:
            begin
                if (bif_cur == 2'd0)
                begin
                    az_next  = {az_reg[15:8], b};
                    bif_next = 2'd1;
                end
                else
                begin
                    az_next    = {b, az_reg[7:0]};
                    bif_next   = 2'd0;
                    rec_next   = '0;
                    phase_next = PH_REC;
                end
            end
            PH_REC:
            begin
                if (bif_cur == 2'd0)
                begin
                    dist_next = {dist_reg[15:8], b};
                    bif_next  = 2'd1;
                end
                else if (bif_cur == 2'd1)
                begin
                    dist_next = {b, dist_reg[7:0]};
                    bif_next  = 2'd2;
                end
                else
                begin
                    point    = 1'b1;
                    bif_next = 2'd0;
                    if (last)
                    begin
                        blk_next   = blk_cur + 4'd1;
                        rec_next   = '0;
                        phase_next = PH_SEARCH;
                        ff_next    = 1'b0;
                    end
                    else
                    begin
                        rec_next = rec_cur + 5'd1;
                    end
                end
            end
            default:
            begin
                if (ff_cur && (b == FLAG_BYTE_LO) && (blk_cur < 4'(MAX_BLOCKS)))
                begin
                    phase_next = PH_AZIM;
                    bif_next   = 2'd0;
                    ff_next    = 1'b0;
                end
                else
                begin
                    ff_next = (b == FLAG_BYTE_HI);
                end
            end
        endcase

        result = '0;
        if (point)
        begin
            result.result_kind      = KIND_POINT;
            result.block_index      = blk_cur;
            result.channel_index    = rec_cur;
            result.azimuth_centideg = az_reg;
            result.distance_units   = dist_reg;
            result.reflectivity     = b;
            result.last_of_block    = last;
        end
        else if (is_mode)
        begin
            result.result_kind   = KIND_MODE;
            result.return_mode   = decode_mode(b);
            result.last_of_block = 1'b1;
        end
        result_valid = point || is_mode;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEARCH;
            ff_reg    <= 1'b0;
            pos_reg   <= '0;
            blk_reg   <= '0;
            rec_reg   <= '0;
            bif_reg   <= '0;
            az_reg    <= '0;
            dist_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            ff_reg    <= ff_next;
            pos_reg   <= pos_next;
            blk_reg   <= blk_next;
            rec_reg   <= rec_next;
            bif_reg   <= bif_next;
            az_reg    <= az_next;
            dist_reg  <= dist_next;
        end
    end

endmodule

[hdl/lidar_data_block_parser_core.sv]
// Latency: a result item is presented in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; the input is stalled only while a held result is not taken.
// The parser state and the result register update on the same edge, so no stage bubbles.
// Reset clears the parser state and the output valid, and sets the mode byte offset to 1204.
module lidar_data_block_parser_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ldbp_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ldbp_pkg::out_item_t  out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [10:0]          cfg_data
);
    import ldbp_pkg::*;

    logic [10:0] offset_reg;
    logic        out_valid_reg;
    out_item_t   out_data_reg;
    out_item_t   result;
    logic        result_valid;
    logic        accept;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    ldbp_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .in_item      (in_data),
        .mode_offset  (offset_reg),
        .result       (result),
        .result_valid (result_valid)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= MODE_OFFSET_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            offset_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= accept && result_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && result_valid)
        begin
            out_data_reg <= result;
        end
    end

endmodule
